### design/tscp_pkg.sv
// ----------------------------------------------------------------------------
// tscp_pkg
// Shared types and constants for the time set command parser.
// ----------------------------------------------------------------------------
package tscp_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned EventW  = 3;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinW    = 6;
   localparam int unsigned SecW    = 6;
   localparam int unsigned AccW    = 7;
   localparam int unsigned RspW    = 32;

   // command characters
   localparam logic [ByteW-1:0] ChBang  = 8'h21;
   localparam logic [ByteW-1:0] ChT     = 8'h54;
   localparam logic [ByteW-1:0] ChI     = 8'h49;
   localparam logic [ByteW-1:0] ChM     = 8'h4D;
   localparam logic [ByteW-1:0] ChE     = 8'h45;
   localparam logic [ByteW-1:0] ChColon = 8'h3A;
   localparam logic [ByteW-1:0] ChHash  = 8'h23;
   localparam logic [ByteW-1:0] ChZero  = 8'h30;
   localparam logic [ByteW-1:0] ChNine  = 8'h39;

   localparam logic [AccW-1:0] HourMax = 7'd23;
   localparam logic [AccW-1:0] MinMax  = 7'd59;
   localparam logic [AccW-1:0] SecMax  = 7'd59;

   typedef enum logic [EventW-1:0] {
      EV_NONE    = 3'd0,
      EV_NODIGIT = 3'd1,
      EV_HOUR    = 3'd2,
      EV_MINUTE  = 3'd3,
      EV_SECOND  = 3'd4,
      EV_OK      = 3'd5
   } event_type;

   typedef struct packed {
      logic [SecW-1:0]  set_second;
      logic [MinW-1:0]  set_minute;
      logic [HourW-1:0] set_hour;
      event_type        event_code;
      logic [ByteW-1:0] echo_byte;
   } rsp_type;

endpackage

### design/tscp_in_stage.sv
// ----------------------------------------------------------------------------
// tscp_in_stage
// Input register: holds one received character until the parser consumes it.
// ----------------------------------------------------------------------------
module tscp_in_stage
   import tscp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ByteW-1:0] req_byte,
   input  logic             consume,
   output logic             hold_valid,
   output logic [ByteW-1:0] hold_byte
);

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] byte_ff, byte_in;

   assign req_tready = !valid_ff || consume;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

### design/tscp_core.sv
// ----------------------------------------------------------------------------
// tscp_core
// Parse state machine and decimal accumulators; forms one result per character.
// ----------------------------------------------------------------------------
module tscp_core
   import tscp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [ByteW-1:0] rx_byte,
   output rsp_type          rsp
);

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_BANG = 4'd1,
      PH_T    = 4'd2,
      PH_I    = 4'd3,
      PH_M    = 4'd4,
      PH_E    = 4'd5,
      PH_H1   = 4'd6,
      PH_H2   = 4'd7,
      PH_M1   = 4'd8,
      PH_M2   = 4'd9,
      PH_S1   = 4'd10,
      PH_S2   = 4'd11,
      PH_WAIT = 4'd12
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [AccW-1:0] hour_ff, hour_in;
   logic [AccW-1:0] min_ff, min_in;
   logic [AccW-1:0] sec_ff, sec_in;

   logic            is_digit;
   logic [3:0]      digit;
   logic [AccW-1:0] digit_x10;
   logic [AccW-1:0] hour_sum, min_sum, sec_sum;
   phase_type       kw_fail;

   assign is_digit  = (rx_byte >= ChZero) && (rx_byte <= ChNine);
   assign digit     = rx_byte[3:0];
   assign digit_x10 = {digit, 3'b000} + {2'b00, digit, 1'b0};
   assign hour_sum  = hour_ff + {3'b000, digit};
   assign min_sum   = min_ff + {3'b000, digit};
   assign sec_sum   = sec_ff + {3'b000, digit};
   // keyword mismatch: '!' restarts the match
   assign kw_fail   = (rx_byte == ChBang) ? PH_BANG : PH_IDLE;

   always_comb begin
      phase_in       = phase_ff;
      hour_in        = hour_ff;
      min_in         = min_ff;
      sec_in         = sec_ff;
      rsp.echo_byte  = rx_byte;
      rsp.event_code = EV_NONE;
      rsp.set_hour   = '0;
      rsp.set_minute = '0;
      rsp.set_second = '0;
      case (phase_ff)
         PH_BANG: phase_in = (rx_byte == ChT)     ? PH_T  : kw_fail;
         PH_T:    phase_in = (rx_byte == ChI)     ? PH_I  : kw_fail;
         PH_I:    phase_in = (rx_byte == ChM)     ? PH_M  : kw_fail;
         PH_M:    phase_in = (rx_byte == ChE)     ? PH_E  : kw_fail;
         PH_E:    phase_in = (rx_byte == ChColon) ? PH_H1 : kw_fail;
         PH_H1, PH_M1, PH_S1: begin
            if (!is_digit) begin
               rsp.event_code = EV_NODIGIT;
               phase_in       = PH_IDLE;
            end else begin
               if (phase_ff == PH_H1) begin
                  hour_in  = digit_x10;
                  phase_in = PH_H2;
               end else if (phase_ff == PH_M1) begin
                  min_in   = digit_x10;
                  phase_in = PH_M2;
               end else begin
                  sec_in   = digit_x10;
                  phase_in = PH_S2;
               end
            end
         end
         PH_H2: begin
            if (!is_digit) begin
               rsp.event_code = EV_NODIGIT;
               phase_in       = PH_IDLE;
            end else begin
               hour_in = hour_sum;
               if (hour_sum > HourMax) begin
                  rsp.event_code = EV_HOUR;
                  phase_in       = PH_IDLE;
               end else begin
                  phase_in = PH_M1;
               end
            end
         end
         PH_M2: begin
            if (!is_digit) begin
               rsp.event_code = EV_NODIGIT;
               phase_in       = PH_IDLE;
            end else begin
               min_in = min_sum;
               if (min_sum > MinMax) begin
                  rsp.event_code = EV_MINUTE;
                  phase_in       = PH_IDLE;
               end else begin
                  phase_in = PH_S1;
               end
            end
         end
         PH_S2: begin
            if (!is_digit) begin
               rsp.event_code = EV_NODIGIT;
               phase_in       = PH_IDLE;
            end else begin
               sec_in = sec_sum;
               if (sec_sum > SecMax) begin
                  rsp.event_code = EV_SECOND;
                  phase_in       = PH_IDLE;
               end else begin
                  phase_in = PH_WAIT;
               end
            end
         end
         PH_WAIT: begin
            if (rx_byte == ChHash) begin
               rsp.event_code = EV_OK;
               rsp.set_hour   = hour_ff[HourW-1:0];
               rsp.set_minute = min_ff[MinW-1:0];
               rsp.set_second = sec_ff[SecW-1:0];
               phase_in       = PH_IDLE;
            end
         end
         default: phase_in = kw_fail;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hour_ff  <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
      end
   end

endmodule

### design/tscp_out_stage.sv
// ----------------------------------------------------------------------------
// tscp_out_stage
// Result register on the response side.
// ----------------------------------------------------------------------------
module tscp_out_stage
   import tscp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    has_room,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign has_room = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

### design/time_set_command_parser_unit.sv
// ----------------------------------------------------------------------------
// time_set_command_parser_unit
// Recognizes "!TIME:HHMMSS#" one character per request, echoes each
// character with an event code and reports the parsed time on success.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)
//  req_    | in  | [7:0] rx_byte
//  rsp_    | out | [7:0] echo_byte, [10:8] event_code, [15:11] set_hour,
//          |     | [21:16] set_minute, [27:22] set_second, [31:28] zero
//
//  One request per cycle sustained while responses are taken; a request passes
//  through the input register, parse logic and result register.
//  Reset (synchronous) empties both registers and returns the parser to idle.
//  A stalled response holds in the result register while the input register
//  still takes one more request.
// ----------------------------------------------------------------------------
module time_set_command_parser_unit
   import tscp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [ByteW-1:0] req_tdata,  // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [RspW-1:0] rsp_tdata   // echo, event, hour, minute, second, pad
);

   logic             hold_valid;
   logic [ByteW-1:0] hold_byte;
   logic             has_room;
   logic             step;
   rsp_type          core_rsp;
   rsp_type          out_rsp;

   assign step = hold_valid && has_room;

   tscp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .consume    (step),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   tscp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (hold_byte),
      .rsp     (core_rsp)
   );

   tscp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_data  (core_rsp),
      .has_room   (has_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (out_rsp)
   );

   assign rsp_tdata = {{(RspW - $bits(rsp_type)){1'b0}}, out_rsp};

endmodule

### design/tscp_checker.sv
// ----------------------------------------------------------------------------
// tscp_checker
// Port-level checks for the time set command parser.
// ----------------------------------------------------------------------------
module tscp_checker
   import tscp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RspW-1:0]  rsp_tdata
);

   logic [EventW-1:0] ev;
   logic [HourW-1:0]  hr;
   logic [MinW-1:0]   mn;
   logic [SecW-1:0]   sc;

   assign ev = rsp_tdata[10:8];
   assign hr = rsp_tdata[15:11];
   assign mn = rsp_tdata[21:16];
   assign sc = rsp_tdata[27:22];

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // time fields are zero unless the event is success
   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ev != EV_OK |-> hr == '0 && mn == '0 && sc == '0)
      else $error("time fields set without success");

   // success comes only on '#' with an in-range time
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ev == EV_OK |->
         rsp_tdata[7:0] == ChHash && hr <= 5'd23 && mn <= 6'd59 && sc <= 6'd59)
      else $error("bad success response");

   // a response follows an accepted request when the output was free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("response missing after request");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind time_set_command_parser_unit tscp_checker u_tscp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/tb_time_set_command_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_set_command_parser_unit
// Streams characters into the time set command parser, some as well formed
// "!TIME:HHMMSS#" commands with random digits and some as broken commands or
// noise. The testbench runs its own copy of the parser and compares every echo
// response field by field, in order.
// ----------------------------------------------------------------------------
module tb_time_set_command_parser_unit;
   import tscp_pkg::*;

   localparam int ItemTarget  = 1000;
   localparam int CycleLimit  = 200000;
   localparam int HoldOffAt   = 400;
   localparam int HoldOffLen  = 200;
   localparam int DrainCycles = 8;
   localparam int RspBits     = $bits(rsp_type);

   typedef enum logic [3:0] {
      PH_IDLE, PH_BANG, PH_T, PH_I, PH_M, PH_E,
      PH_H1, PH_H2, PH_M1, PH_M2, PH_S1, PH_S2, PH_WAIT
   } parse_phase_type;

   // Tracks the command parse and holds the echo responses still to come.
   class time_command_scoreboard;
      parse_phase_type phase;
      logic [AccW-1:0] hour_acc, minute_acc, second_acc;
      rsp_type pending_echoes[$];
      int fail_count;
      int echoes_checked;
      int event_hits[6];

      function new();
         phase = PH_IDLE;
         hour_acc = '0;
         minute_acc = '0;
         second_acc = '0;
         fail_count = 0;
         echoes_checked = 0;
         foreach (event_hits[i]) event_hits[i] = 0;
      endfunction

      function parse_phase_type keyword_step(logic [ByteW-1:0] b, logic [ByteW-1:0] want,
                                             parse_phase_type nxt);
         if (b == want) return nxt;
         if (b == ChBang) return PH_BANG;
         return PH_IDLE;
      endfunction

      function void note_rx_char(logic [ByteW-1:0] b);
         rsp_type r;
         logic [AccW-1:0] d;
         bit is_digit;
         r = '0;
         r.echo_byte = b;
         r.event_code = EV_NONE;
         is_digit = (b >= ChZero) && (b <= ChNine);
         d = AccW'(b - ChZero);
         case (phase)
            PH_BANG: phase = keyword_step(b, ChT, PH_T);
            PH_T:    phase = keyword_step(b, ChI, PH_I);
            PH_I:    phase = keyword_step(b, ChM, PH_M);
            PH_M:    phase = keyword_step(b, ChE, PH_E);
            PH_E:    phase = keyword_step(b, ChColon, PH_H1);
            PH_H1, PH_M1, PH_S1: begin
               if (!is_digit) begin
                  r.event_code = EV_NODIGIT;
                  phase = PH_IDLE;
               end else begin
                  if (phase == PH_H1) hour_acc = d * 7'd10;
                  else if (phase == PH_M1) minute_acc = d * 7'd10;
                  else second_acc = d * 7'd10;
                  phase = parse_phase_type'(phase + 4'd1);
               end
            end
            PH_H2, PH_M2, PH_S2: begin
               if (!is_digit) begin
                  r.event_code = EV_NODIGIT;
                  phase = PH_IDLE;
               end else if (phase == PH_H2) begin
                  hour_acc = hour_acc + d;
                  if (hour_acc > HourMax) begin
                     r.event_code = EV_HOUR;
                     phase = PH_IDLE;
                  end else phase = PH_M1;
               end else if (phase == PH_M2) begin
                  minute_acc = minute_acc + d;
                  if (minute_acc > MinMax) begin
                     r.event_code = EV_MINUTE;
                     phase = PH_IDLE;
                  end else phase = PH_S1;
               end else begin
                  second_acc = second_acc + d;
                  if (second_acc > SecMax) begin
                     r.event_code = EV_SECOND;
                     phase = PH_IDLE;
                  end else phase = PH_WAIT;
               end
            end
            PH_WAIT: begin
               // everything but the closing mark is swallowed here
               if (b == ChHash) begin
                  r.event_code = EV_OK;
                  r.set_hour = hour_acc[HourW-1:0];
                  r.set_minute = minute_acc[MinW-1:0];
                  r.set_second = second_acc[SecW-1:0];
                  phase = PH_IDLE;
               end
            end
            default: phase = (b == ChBang) ? PH_BANG : PH_IDLE;
         endcase
         pending_echoes.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            fail_count++;
         end
      endfunction

      function void check_echo(logic [RspW-1:0] data);
         rsp_type got, want;
         got = data[RspBits-1:0];
         if (pending_echoes.size() == 0) begin
            $display("%0t: response with nothing pending, actual 0x%0h", $time, data);
            fail_count++;
            return;
         end
         want = pending_echoes.pop_front();
         echoes_checked++;
         if (want.event_code <= EV_OK) event_hits[want.event_code]++;
         compare_field("echo_byte", int'(want.echo_byte), int'(got.echo_byte));
         compare_field("event_code", int'(want.event_code), int'(got.event_code));
         compare_field("set_hour", int'(want.set_hour), int'(got.set_hour));
         compare_field("set_minute", int'(want.set_minute), int'(got.set_minute));
         compare_field("set_second", int'(want.set_second), int'(got.set_second));
         compare_field("pad", 0, int'(data[RspW-1:RspBits]));
      endfunction

      function int pending();
         return pending_echoes.size();
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [ByteW-1:0] req_tdata = '0;  // [7:0] rx_byte
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RspW-1:0] rsp_tdata;        // echo, event, hour, minute, second, pad

   time_command_scoreboard sb = new();
   int  chars_sent = 0;
   int  burst_left = 0;
   int  cycle_count = 0;
   bit  holdoff_req = 1'b0;

   time_set_command_parser_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses still pending",
                  cycle_count, sb.pending());
         $display("time_set_command_parser_unit verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_echo(rsp_tdata);
   end

   // Receiver: stall pattern is redrawn at random from four modes, plus one long hold-off.
   initial begin : receiver
      int rx_mode;
      int rx_cyc;
      bit holdoff_done;
      rx_cyc = 0;
      rx_mode = 0;
      holdoff_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (holdoff_req && !holdoff_done) begin
            holdoff_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HoldOffLen) @(negedge clock);
         end else begin
            if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) != 0);
               2: rsp_tready <= (rx_cyc % 4 == 0);
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
            rx_cyc++;
            @(negedge clock);
         end
      end
   end

   // Entered and left just after a falling edge.
   task automatic send_char(input logic [ByteW-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_rx_char(b);
      chars_sent++;
      if (chars_sent == HoldOffAt) holdoff_req = 1'b1;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic logic [ByteW-1:0] pick_non_digit();
      logic [ByteW-1:0] b;
      do b = ByteW'($urandom_range(0, 255)); while (b >= ChZero && b <= ChNine);
      return b;
   endfunction

   // Well-formed command with random digits; kind picks what goes wrong, if anything.
   task automatic send_time_command();
      int kind, bad_pos, fill;
      int val[3];
      logic [ByteW-1:0] b;
      kind = $urandom_range(0, 9);
      val[0] = $urandom_range(0, 23);
      val[1] = $urandom_range(0, 59);
      val[2] = $urandom_range(0, 59);
      bad_pos = (kind == 8) ? $urandom_range(0, 5) : -1;
      if (kind == 6) begin
         case ($urandom_range(0, 2))
            0: val[0] = $urandom_range(24, 99);
            1: val[1] = $urandom_range(60, 99);
            default: val[2] = $urandom_range(60, 99);
         endcase
      end else if (kind == 7) begin
         foreach (val[i]) val[i] = $urandom_range(0, 99);
      end
      send_text("!TIME:");
      for (int i = 0; i < 6; i++) begin
         if (i == bad_pos) begin
            send_char(pick_non_digit());
            return;
         end
         b = ChZero + ByteW'((i % 2 == 0) ? val[i / 2] / 10 : val[i / 2] % 10);
         send_char(b);
      end
      fill = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (fill) begin
         do b = ByteW'($urandom_range(0, 255)); while (b == ChHash);
         send_char(b);
      end
      if ($urandom_range(0, 9) != 0) send_char(ChHash);
   endtask

   task automatic send_broken_keyword();
      string kw;
      int n;
      kw = "!TIME:";
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) send_char(kw[i]);
      send_char($urandom_range(0, 1) ? ChBang : ByteW'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      int pick;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full range time with '!' ignored while waiting for the closing mark
      send_text("!TIME:235959!#");
      // keyword restart on '!', first hour digit unchecked, then a non-digit
      send_text("!TI!TIME:9");
      send_char(8'h00);
      send_char(8'hFF);
      send_text("!TIME:000000#");

      while (chars_sent < ItemTarget) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) send_time_command();
         else if (pick < 17) send_broken_keyword();
         else repeat ($urandom_range(1, 5)) send_char(ByteW'($urandom_range(0, 255)));
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d characters, checked %0d echoes: %0d times set, %0d non-digit,",
               chars_sent, sb.echoes_checked, sb.event_hits[EV_OK], sb.event_hits[EV_NODIGIT]);
      $display("%0d hour, %0d minute and %0d second range errors, %0d mismatches",
               sb.event_hits[EV_HOUR], sb.event_hits[EV_MINUTE], sb.event_hits[EV_SECOND],
               sb.fail_count);
      if (sb.fail_count == 0) begin
         $display("time_set_command_parser_unit verification clean");
      end else begin
         $display("time_set_command_parser_unit verification failed");
      end
      $finish;
   end

endmodule
